// File: sv/mfg_pkg.sv
// Shared types, constants and saturation helpers for the factorization gradient engine.
`timescale 1ns / 1ps
`default_nettype none

package mfg_pkg;

  // Storage geometry.
  localparam int MAX_ROWS = 1024;
  localparam int MAX_COLS = 1024;
  localparam int MAX_RANK = 16;
  localparam int ROW_W    = $clog2(MAX_ROWS);
  localparam int COL_W    = $clog2(MAX_COLS);
  localparam int RANK_W   = $clog2(MAX_RANK);
  localparam int ADDR_W   = ROW_W + RANK_W;

  // Field and register widths.
  localparam int DATA_W   = 32;
  localparam int GRAD_W   = 48;
  localparam int PROD_W   = 64;
  localparam int ACC_W    = 52;
  localparam int LR_W     = 32;
  localparam int RANKC_W  = 5;
  localparam int CNTC_W   = 11;
  localparam int CFG_IW   = 2;

  // Request codes.
  typedef enum logic [2:0] {
    REQ_WR_ROW = 3'd0,
    REQ_WR_COL = 3'd1,
    REQ_ENTRY  = 3'd2,
    REQ_RD_ROW = 3'd3,
    REQ_RD_COL = 3'd4,
    REQ_APPLY  = 3'd5
  } mfg_req_type_t;

  // Configuration register indexes.
  typedef enum logic [CFG_IW-1:0] {
    CFG_LEARN_RATE = 2'd0,
    CFG_RANK       = 2'd1,
    CFG_ROWS       = 2'd2,
    CFG_COLS       = 2'd3
  } mfg_cfg_idx_t;

  // Sequencer states.
  typedef enum logic [3:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_FWR,
    ST_RD,
    ST_RDW,
    ST_DOT,
    ST_DOT_DRAIN,
    ST_RESID,
    ST_GRAD,
    ST_GRAD_DRAIN,
    ST_APPLY,
    ST_APPLY_DRAIN,
    ST_DONE
  } mfg_state_t;

  // Input item.
  typedef struct packed {
    logic [2:0]               req_type;
    logic [ROW_W-1:0]         row_index;
    logic [COL_W-1:0]         col_index;
    logic [RANK_W-1:0]        factor_index;
    logic signed [DATA_W-1:0] data_value;
  } mfg_req_t;

  // Result item.
  typedef struct packed {
    logic signed [DATA_W-1:0] result_value;
    logic                     saturated;
  } mfg_rsp_t;

  // Saturate a 53-bit value to 32 bits.
  function automatic logic signed [DATA_W-1:0] sat32(input logic signed [52:0] v);
    if (v > 53'sh7FFFFFFF) begin
      return 32'sh7FFFFFFF;
    end else if (v < -53'sh80000000) begin
      return -32'sh80000000;
    end
    return v[DATA_W-1:0];
  endfunction

  function automatic logic ovf32(input logic signed [52:0] v);
    return (v > 53'sh7FFFFFFF) || (v < -53'sh80000000);
  endfunction

  // Saturate a 49-bit sum to 48 bits.
  function automatic logic signed [GRAD_W-1:0] sat48(input logic signed [48:0] v);
    if (v[48] != v[47]) begin
      return v[48] ? {1'b1, {(GRAD_W-1){1'b0}}} : {1'b0, {(GRAD_W-1){1'b1}}};
    end
    return v[GRAD_W-1:0];
  endfunction

  function automatic logic ovf48(input logic signed [48:0] v);
    return v[48] != v[47];
  endfunction

endpackage

`default_nettype wire

// File: sv/mfg_ram.sv
// Generic simple dual-port synchronous RAM with a registered read.
`timescale 1ns / 1ps
`default_nettype none

module mfg_ram #(
  parameter int DATA_W = 32,
  parameter int ADDR_W = 14
) (
  input  wire logic              clk,
  input  wire logic              we,
  input  wire logic [ADDR_W-1:0] waddr,
  input  wire logic [DATA_W-1:0] wdata,
  input  wire logic [ADDR_W-1:0] raddr,
  output logic      [DATA_W-1:0] rdata
);

  logic [DATA_W-1:0] mem [1<<ADDR_W];

  // Write port.
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  // Read port, old data on a same-address write.
  always_ff @(posedge clk) begin
    rdata <= mem[raddr];
  end

endmodule

`default_nettype wire

// File: sv/matrix_factor_gradient_step.sv
// Top level of the matrix factorization gradient engine: sequencer and datapath.
`timescale 1ns / 1ps
`default_nettype none

// Gradient-descent engine for one block of a low-rank matrix factorization.
// An item is accepted at a clock edge with start high and busy low; busy stays
// high until its result has been shown. Every item gives exactly one result,
// shown on out_data for one cycle with out_valid high; the receiver cannot
// stall, so the result is taken in that cycle.
// Steps per item, from acceptance to the result strobe in ST_DONE:
//   factor write: ST_FWR; factor read: ST_RD then ST_RDW; unknown code:
//   straight to ST_DONE; observed entry: dot pass, residual, gradient pass,
//   set by the single read port of each factor and gradient RAM, one rank
//   element per cycle; apply: one element of every store per cycle over the
//   whole store, which also clears both gradient stores.
// Configuration writes go through cfg_valid/cfg_ready (always ready) and are
// meant to be issued while the block is idle.
// After reset the block runs a clearing pass over every address of both
// gradient RAMs with busy high; configuration writes are taken meanwhile.
module matrix_factor_gradient_step
  import mfg_pkg::*;
(
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire logic              start,
  output logic                   busy,
  input  wire mfg_req_t          in_data,
  output logic                   out_valid,
  output mfg_rsp_t               out_data,
  input  wire logic              cfg_valid,
  output logic                   cfg_ready,
  input  wire logic [CFG_IW-1:0] cfg_index,
  input  wire logic [LR_W-1:0]   cfg_data
);

  // Control state.
  mfg_state_t state_r, state_nxt;
  logic [ADDR_W-1:0] cnt_r, cnt_nxt;
  logic s1_vld_r, s2_vld_r, s3_vld_r;

  // Configuration registers.
  logic [LR_W-1:0]    lr_r;
  logic [RANKC_W-1:0] rank_raw_r;
  logic [CNTC_W-1:0]  rows_raw_r, cols_raw_r;
  logic [RANKC_W-1:0] rank_c;
  logic [CNTC_W-1:0]  rows_c, cols_c;
  logic [RANK_W-1:0]  rank_m1;

  // Item and datapath registers.
  mfg_req_t item_r;
  logic [ADDR_W-1:0] s1_addr_r, s2_addr_r, s3_addr_r;
  logic signed [ACC_W-1:0]  acc_r;
  logic signed [DATA_W-1:0] res_r;
  logic sat_r;
  logic signed [PROD_W-1:0] prod_row_r, prod_col_r;
  logic [GRAD_W-1:0]        low_row_r, low_col_r;
  logic signed [GRAD_W-1:0] g_row_r, g_col_r;
  logic signed [DATA_W-1:0] f_row_r, f_col_r, f3_row_r, f3_col_r;
  logic signed [GRAD_W-1:0] dlt_row_r, dlt_col_r;

  // Memory ports.
  logic                 rf_we, cf_we, rg_we, cg_we;
  logic [ADDR_W-1:0]    rf_waddr, cf_waddr, rg_waddr, cg_waddr;
  logic [ADDR_W-1:0]    rf_raddr, cf_raddr, rg_raddr, cg_raddr;
  logic [DATA_W-1:0]    rf_wdata, cf_wdata, rf_rdata, cf_rdata;
  logic [GRAD_W-1:0]    rg_wdata, cg_wdata, rg_rdata, cg_rdata;

  // Phase decodes and helpers.
  logic accept, issue, last_k, last_all, last_iss;
  logic dph, gph, aph;
  logic signed [32:0] mul_a_row, mul_b_row, mul_a_col, mul_b_col;
  logic signed [65:0] mul_row, mul_col;
  logic [GRAD_W-1:0]  lo_row, lo_col;
  logic signed [48:0] gsum_row, gsum_col;
  logic signed [PROD_W-1:0] asum_row, asum_col;
  logic signed [48:0] fsum_row, fsum_col;
  logic signed [52:0] diff;
  logic row_in, col_in;

  assign accept    = start && !busy;
  assign busy      = (state_r != ST_IDLE);
  assign cfg_ready = 1'b1;
  assign issue     = (state_r == ST_DOT) || (state_r == ST_GRAD) || (state_r == ST_APPLY);
  assign dph       = (state_r == ST_DOT) || (state_r == ST_DOT_DRAIN);
  assign gph       = (state_r == ST_GRAD) || (state_r == ST_GRAD_DRAIN);
  assign aph       = (state_r == ST_APPLY) || (state_r == ST_APPLY_DRAIN);

  // Clamp the configuration registers to their legal ranges.
  always_comb begin
    if (rank_raw_r == '0) begin
      rank_c = RANKC_W'(1);
    end else if (rank_raw_r > RANKC_W'(MAX_RANK)) begin
      rank_c = RANKC_W'(MAX_RANK);
    end else begin
      rank_c = rank_raw_r;
    end
    if (rows_raw_r == '0) begin
      rows_c = CNTC_W'(1);
    end else if (rows_raw_r > CNTC_W'(MAX_ROWS)) begin
      rows_c = CNTC_W'(MAX_ROWS);
    end else begin
      rows_c = rows_raw_r;
    end
    if (cols_raw_r == '0) begin
      cols_c = CNTC_W'(1);
    end else if (cols_raw_r > CNTC_W'(MAX_COLS)) begin
      cols_c = CNTC_W'(MAX_COLS);
    end else begin
      cols_c = cols_raw_r;
    end
  end

  assign rank_m1  = RANK_W'(rank_c - RANKC_W'(1));
  assign last_k   = (cnt_r[RANK_W-1:0] == rank_m1);
  assign last_all = &cnt_r;
  assign last_iss = ((state_r == ST_DOT) || (state_r == ST_GRAD)) ? last_k : last_all;

  // Configuration writes.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      lr_r       <= LR_W'(43);
      rank_raw_r <= RANKC_W'(MAX_RANK);
      rows_raw_r <= CNTC_W'(MAX_ROWS);
      cols_raw_r <= CNTC_W'(MAX_COLS);
    end else if (cfg_valid && cfg_ready) begin
      unique case (mfg_cfg_idx_t'(cfg_index))
        CFG_LEARN_RATE: lr_r       <= cfg_data;
        CFG_RANK:       rank_raw_r <= cfg_data[RANKC_W-1:0];
        CFG_ROWS:       rows_raw_r <= cfg_data[CNTC_W-1:0];
        CFG_COLS:       cols_raw_r <= cfg_data[CNTC_W-1:0];
        default: ;
      endcase
    end
  end

  // Next state.
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ST_CLEAR: begin
        if (last_all) state_nxt = ST_IDLE;
      end
      ST_IDLE: begin
        if (accept) begin
          case (in_data.req_type) inside
            REQ_WR_ROW, REQ_WR_COL: state_nxt = ST_FWR;
            REQ_RD_ROW, REQ_RD_COL: state_nxt = ST_RD;
            REQ_ENTRY:              state_nxt = ST_DOT;
            REQ_APPLY:              state_nxt = ST_APPLY;
            default:                state_nxt = ST_DONE;
          endcase
        end
      end
      ST_FWR:         state_nxt = ST_DONE;
      ST_RD:          state_nxt = ST_RDW;
      ST_RDW:         state_nxt = ST_DONE;
      ST_DOT: begin
        if (last_k) state_nxt = ST_DOT_DRAIN;
      end
      ST_DOT_DRAIN: begin
        if (!s1_vld_r && !s2_vld_r) state_nxt = ST_RESID;
      end
      ST_RESID:       state_nxt = ST_GRAD;
      ST_GRAD: begin
        if (last_k) state_nxt = ST_GRAD_DRAIN;
      end
      ST_GRAD_DRAIN: begin
        if (!s1_vld_r && !s2_vld_r) state_nxt = ST_DONE;
      end
      ST_APPLY: begin
        if (last_all) state_nxt = ST_APPLY_DRAIN;
      end
      ST_APPLY_DRAIN: begin
        if (!s1_vld_r && !s2_vld_r && !s3_vld_r) state_nxt = ST_DONE;
      end
      ST_DONE:        state_nxt = ST_IDLE;
      default:        state_nxt = ST_IDLE;
    endcase
  end

  // Element counter for the sweeps and rank loops.
  always_comb begin
    if ((issue || (state_r == ST_CLEAR)) && !last_iss) begin
      cnt_nxt = cnt_r + ADDR_W'(1);
    end else begin
      cnt_nxt = '0;
    end
  end

  // Apply write-back is limited to the walked rows, columns and rank.
  assign row_in = ({1'b0, s3_addr_r[ADDR_W-1:RANK_W]} < rows_c) &&
                  ({1'b0, s3_addr_r[RANK_W-1:0]} < rank_c);
  assign col_in = ({1'b0, s3_addr_r[ADDR_W-1:RANK_W]} < cols_c) &&
                  ({1'b0, s3_addr_r[RANK_W-1:0]} < rank_c);
  assign fsum_row = 49'(f3_row_r) + 49'(dlt_row_r);
  assign fsum_col = 49'(f3_col_r) + 49'(dlt_col_r);
  assign gsum_row = 49'(g_row_r) + 49'($signed(prod_row_r[PROD_W-1:16]));
  assign gsum_col = 49'(g_col_r) + 49'($signed(prod_col_r[PROD_W-1:16]));

  // Memory control outputs.
  always_comb begin
    rf_raddr = aph ? cnt_r :
               (state_r == ST_RD) ? {item_r.row_index, item_r.factor_index} :
               {item_r.row_index, cnt_r[RANK_W-1:0]};
    cf_raddr = aph ? cnt_r :
               (state_r == ST_RD) ? {item_r.col_index, item_r.factor_index} :
               {item_r.col_index, cnt_r[RANK_W-1:0]};
    rg_raddr = aph ? cnt_r : {item_r.row_index, cnt_r[RANK_W-1:0]};
    cg_raddr = aph ? cnt_r : {item_r.col_index, cnt_r[RANK_W-1:0]};

    // Factor writes: a direct write, or the apply update.
    rf_we    = ((state_r == ST_FWR) && (item_r.req_type == REQ_WR_ROW)) ||
               (aph && s3_vld_r && row_in);
    cf_we    = ((state_r == ST_FWR) && (item_r.req_type == REQ_WR_COL)) ||
               (aph && s3_vld_r && col_in);
    rf_waddr = (state_r == ST_FWR) ? {item_r.row_index, item_r.factor_index} : s3_addr_r;
    cf_waddr = (state_r == ST_FWR) ? {item_r.col_index, item_r.factor_index} : s3_addr_r;
    rf_wdata = (state_r == ST_FWR) ? item_r.data_value : sat32(53'(fsum_row));
    cf_wdata = (state_r == ST_FWR) ? item_r.data_value : sat32(53'(fsum_col));

    // Gradient writes: clearing, or accumulation of an entry.
    if ((state_r == ST_CLEAR) || (state_r == ST_APPLY)) begin
      rg_we    = 1'b1;
      cg_we    = 1'b1;
      rg_waddr = cnt_r;
      cg_waddr = cnt_r;
      rg_wdata = '0;
      cg_wdata = '0;
    end else begin
      rg_we    = gph && s2_vld_r;
      cg_we    = gph && s2_vld_r;
      rg_waddr = {item_r.row_index, s2_addr_r[RANK_W-1:0]};
      cg_waddr = {item_r.col_index, s2_addr_r[RANK_W-1:0]};
      rg_wdata = sat48(gsum_row);
      cg_wdata = sat48(gsum_col);
    end
  end

  // Stage 1 multiplier operands per phase.
  always_comb begin
    mul_a_row = 33'($signed(rf_rdata));
    mul_b_row = 33'($signed(cf_rdata));
    mul_a_col = 33'(res_r);
    mul_b_col = 33'($signed(rf_rdata));
    if (gph) begin
      mul_a_row = 33'(res_r);
    end else if (aph) begin
      mul_a_row = 33'($signed(rg_rdata[GRAD_W-1:16]));
      mul_b_row = $signed({1'b0, lr_r});
      mul_a_col = 33'($signed(cg_rdata[GRAD_W-1:16]));
      mul_b_col = $signed({1'b0, lr_r});
    end
  end

  assign mul_row  = mul_a_row * mul_b_row;
  assign mul_col  = mul_a_col * mul_b_col;
  assign lo_row   = {32'b0, rg_rdata[15:0]} * {16'b0, lr_r};
  assign lo_col   = {32'b0, cg_rdata[15:0]} * {16'b0, lr_r};
  assign asum_row = prod_row_r + $signed({32'b0, low_row_r[GRAD_W-1:16]});
  assign asum_col = prod_col_r + $signed({32'b0, low_col_r[GRAD_W-1:16]});
  assign diff     = 53'(item_r.data_value) - 53'(acc_r);

  // Control registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r  <= ST_CLEAR;
      cnt_r    <= '0;
      s1_vld_r <= 1'b0;
      s2_vld_r <= 1'b0;
      s3_vld_r <= 1'b0;
    end else begin
      state_r  <= state_nxt;
      cnt_r    <= cnt_nxt;
      s1_vld_r <= issue;
      s2_vld_r <= s1_vld_r;
      s3_vld_r <= s2_vld_r && aph;
    end
  end

  // Datapath pipeline.
  always_ff @(posedge clk) begin
    s1_addr_r  <= cnt_r;
    s2_addr_r  <= s1_addr_r;
    s3_addr_r  <= s2_addr_r;
    prod_row_r <= mul_row[PROD_W-1:0];
    prod_col_r <= mul_col[PROD_W-1:0];
    low_row_r  <= lo_row;
    low_col_r  <= lo_col;
    g_row_r    <= rg_rdata;
    g_col_r    <= cg_rdata;
    f_row_r    <= rf_rdata;
    f_col_r    <= cf_rdata;
    dlt_row_r  <= asum_row[PROD_W-1:16];
    dlt_col_r  <= asum_col[PROD_W-1:16];
    f3_row_r   <= f_row_r;
    f3_col_r   <= f_col_r;
    if (accept) begin
      item_r <= in_data;
      acc_r  <= '0;
    end else if (dph && s2_vld_r) begin
      acc_r <= acc_r + ACC_W'($signed(prod_row_r[PROD_W-1:16]));
    end
  end

  // Result value and saturation flag.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      res_r <= '0;
      sat_r <= 1'b0;
    end else if (accept) begin
      res_r <= '0;
      sat_r <= 1'b0;
    end else begin
      if (state_r == ST_RDW) begin
        res_r <= (item_r.req_type == REQ_RD_ROW) ? rf_rdata : cf_rdata;
      end else if (state_r == ST_RESID) begin
        res_r <= sat32(diff);
        sat_r <= sat_r || ovf32(diff);
      end else if (gph && s2_vld_r) begin
        sat_r <= sat_r || ovf48(gsum_row) || ovf48(gsum_col);
      end else if (aph && s3_vld_r) begin
        sat_r <= sat_r || (row_in && ovf32(53'(fsum_row))) ||
                 (col_in && ovf32(53'(fsum_col)));
      end
    end
  end

  // Result strobe.
  always_comb begin
    out_valid              = (state_r == ST_DONE);
    out_data.result_value  = res_r;
    out_data.saturated     = sat_r;
  end

  // Factor and gradient stores.
  mfg_ram #(.DATA_W(DATA_W), .ADDR_W(ADDR_W)) u_row_f (
    .clk(clk), .we(rf_we), .waddr(rf_waddr), .wdata(rf_wdata),
    .raddr(rf_raddr), .rdata(rf_rdata));
  mfg_ram #(.DATA_W(DATA_W), .ADDR_W(ADDR_W)) u_col_f (
    .clk(clk), .we(cf_we), .waddr(cf_waddr), .wdata(cf_wdata),
    .raddr(cf_raddr), .rdata(cf_rdata));
  mfg_ram #(.DATA_W(GRAD_W), .ADDR_W(ADDR_W)) u_row_g (
    .clk(clk), .we(rg_we), .waddr(rg_waddr), .wdata(rg_wdata),
    .raddr(rg_raddr), .rdata(rg_rdata));
  mfg_ram #(.DATA_W(GRAD_W), .ADDR_W(ADDR_W)) u_col_g (
    .clk(clk), .we(cg_we), .waddr(cg_waddr), .wdata(cg_wdata),
    .raddr(cg_raddr), .rdata(cg_rdata));

  // The result strobe lasts one cycle.
  a_strobe_once: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |=> !out_valid) else $error("result strobe longer than one cycle");

  // An accepted item keeps the block busy.
  a_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
    accept |=> busy) else $error("item accepted but block not busy");

  // A result is only shown while the item is still owned.
  a_out_busy: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> busy) else $error("result shown while idle");

  // Reset starts the gradient clearing pass.
  a_reset_clear: assert property (@(posedge clk)
    !rst_n |=> busy) else $error("no clearing pass after reset");

  // Gradient accumulation never overlaps the clearing sweep.
  a_grad_excl: assert property (@(posedge clk) disable iff (!rst_n)
    (gph && s2_vld_r) |-> !((state_r == ST_CLEAR) || (state_r == ST_APPLY)))
    else $error("gradient write conflict");

endmodule

`default_nettype wire
